// ===== rtl/core/chr_pkg.sv =====
// ============================================================================
// chr_pkg
// Shared constants for the command history ring: ring geometry, field widths
// and request codes.
// ============================================================================
package chr_pkg;

    localparam int SLOTS       = 32;
    localparam int LINE_BYTES  = 256;

    localparam int BYTE_W      = 8;
    localparam int REQ_W       = 3;
    localparam int STEPS_W     = 6;

    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = SLOT_W + 1;
    localparam int STORE_DEPTH = SLOTS * LINE_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int MAX_LEN     = (LINE_BYTES - 1 < 255) ? LINE_BYTES - 1 : 255;

    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 24;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH  = 3'd0,
        REQ_OLDER = 3'd1,
        REQ_NEWER = 3'd2,
        REQ_RESET = 3'd3,
        REQ_READ  = 3'd4
    } t_req;

endpackage

// ===== rtl/core/chr_ram.sv =====
// ============================================================================
// chr_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when read is enabled.
// ============================================================================
module chr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/command_history_ring.sv =====
// ============================================================================
// command_history_ring
// Ring of recent text lines with a browse pointer, line bytes and lengths
// held in block RAM.
// ============================================================================
// A push word leaves the block ready for the next word: its byte goes straight
// into the line store while the line is below its maximum length, and the last
// byte of a line writes its length and advances the ring. Recall words that
// give a result and read words move the block to S_RESP, where the length and
// line RAM reads load the result register; S_RESP waits while the previous
// result still holds the result register waiting for i_m_axis_tready. Reset
// browse, recall words that give no result and unused request codes leave the
// block ready for the next word. The RAMs need no clearing pass and the block
// takes words right after reset.
module command_history_ring (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [7:0] line_byte, [15:8] read_offset
    input  logic [chr_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [2:0] req_type
    input  logic [chr_pkg::REQ_W-1:0]         i_s_axis_tuser,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [7:0] line_length, [15:8] data_byte, [21:16] browse_steps, [23:22] zero
    output logic [chr_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // [0] is_read_reply
    output logic                              o_m_axis_tuser
);

    localparam int SLOT_W = chr_pkg::SLOT_W;
    localparam int CNT_W  = chr_pkg::CNT_W;
    localparam int ADDR_W = chr_pkg::ADDR_W;
    localparam int BYTE_W = chr_pkg::BYTE_W;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } t_state;

    function automatic logic [SLOT_W-1:0] f_slot(input logic [SLOT_W-1:0] head,
                                                 input logic [SLOT_W-1:0] step);
        logic [SLOT_W+1:0] tmp;
        tmp = (SLOT_W+2)'(head) + (SLOT_W+2)'(chr_pkg::SLOTS - 1) - (SLOT_W+2)'(step);
        if (tmp >= (SLOT_W+2)'(chr_pkg::SLOTS)) begin
            tmp = tmp - (SLOT_W+2)'(chr_pkg::SLOTS);
        end
        return tmp[SLOT_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] f_addr(input logic [SLOT_W-1:0] slot,
                                                 input logic [BYTE_W-1:0] ofs);
        return ADDR_W'(ADDR_W'(slot) * ADDR_W'(chr_pkg::LINE_BYTES)) + ADDR_W'(ofs);
    endfunction

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [SLOT_W-1:0]   r_head, n_head;
    logic                r_browse, n_browse;
    logic [SLOT_W-1:0]   r_step, n_step;
    logic [BYTE_W-1:0]   r_fill, n_fill;

    logic                r_is_read, n_is_read;
    logic                r_zero, n_zero;
    logic [BYTE_W-1:0]   r_offset, n_offset;

    logic                r_out_valid, n_out_valid;
    logic                r_out_read, n_out_read;
    logic [BYTE_W-1:0]   r_out_len, n_out_len;
    logic [BYTE_W-1:0]   r_out_data, n_out_data;
    logic [chr_pkg::STEPS_W-1:0] r_out_steps, n_out_steps;

    logic                st_we, st_re, ln_we, ln_re;
    logic [ADDR_W-1:0]   st_waddr, st_raddr;
    logic [SLOT_W-1:0]   ln_waddr, ln_raddr;
    logic [BYTE_W-1:0]   ln_wdata;
    logic [BYTE_W-1:0]   st_q, ln_q;

    logic                accept;
    chr_pkg::t_req       req;
    logic [BYTE_W-1:0]   in_byte, in_offset, rd_ofs;
    logic [SLOT_W:0]     older_nxt;
    logic [SLOT_W-1:0]   rd_slot;

    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign req       = chr_pkg::t_req'(i_s_axis_tuser);
    assign in_byte   = i_s_axis_tdata[7:0];
    assign in_offset = i_s_axis_tdata[15:8];
    assign rd_ofs    = (in_offset < BYTE_W'(chr_pkg::MAX_LEN)) ? in_offset : '0;
    assign older_nxt = r_browse ? ((SLOT_W+1)'(r_step) + (SLOT_W+1)'(1)) : '0;
    assign rd_slot   = f_slot(r_head, r_step);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_head      = r_head;
        n_browse    = r_browse;
        n_step      = r_step;
        n_fill      = r_fill;
        n_is_read   = r_is_read;
        n_zero      = r_zero;
        n_offset    = r_offset;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_read  = r_out_read;
        n_out_len   = r_out_len;
        n_out_data  = r_out_data;
        n_out_steps = r_out_steps;

        st_we    = 1'b0;
        st_waddr = f_addr(r_head, r_fill);
        st_re    = 1'b0;
        st_raddr = f_addr(rd_slot, rd_ofs);
        ln_we    = 1'b0;
        ln_waddr = r_head;
        ln_wdata = r_fill;
        ln_re    = 1'b0;
        ln_raddr = rd_slot;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (req)
                        chr_pkg::REQ_PUSH: begin
                            if (r_fill < BYTE_W'(chr_pkg::MAX_LEN)) begin
                                st_we  = 1'b1;
                                n_fill = r_fill + BYTE_W'(1);
                            end
                            if (i_s_axis_tlast) begin
                                ln_we    = 1'b1;
                                ln_wdata = n_fill;
                                n_head   = (r_head == SLOT_W'(chr_pkg::SLOTS - 1)) ?
                                           '0 : r_head + SLOT_W'(1);
                                if (r_count < CNT_W'(chr_pkg::SLOTS)) begin
                                    n_count = r_count + CNT_W'(1);
                                end
                                n_fill = '0;
                            end
                        end
                        chr_pkg::REQ_OLDER: begin
                            if (r_count != '0 && older_nxt < r_count) begin
                                n_browse  = 1'b1;
                                n_step    = older_nxt[SLOT_W-1:0];
                                ln_re     = 1'b1;
                                ln_raddr  = f_slot(r_head, older_nxt[SLOT_W-1:0]);
                                n_is_read = 1'b0;
                                n_zero    = 1'b0;
                                n_state   = S_RESP;
                            end
                        end
                        chr_pkg::REQ_NEWER: begin
                            if (r_browse) begin
                                n_is_read = 1'b0;
                                n_state   = S_RESP;
                                if (r_step == '0) begin
                                    n_browse = 1'b0;
                                    n_zero   = 1'b1;
                                end else begin
                                    n_step   = r_step - SLOT_W'(1);
                                    ln_re    = 1'b1;
                                    ln_raddr = f_slot(r_head, r_step - SLOT_W'(1));
                                    n_zero   = 1'b0;
                                end
                            end
                        end
                        chr_pkg::REQ_RESET: begin
                            n_browse = 1'b0;
                        end
                        chr_pkg::REQ_READ: begin
                            n_is_read = 1'b1;
                            n_zero    = !r_browse;
                            n_offset  = in_offset;
                            ln_re     = r_browse;
                            st_re     = r_browse;
                            n_state   = S_RESP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_read  = r_is_read;
                    n_out_len   = r_zero ? '0 : ln_q;
                    n_out_data  = (r_is_read && !r_zero && r_offset < ln_q) ? st_q : '0;
                    n_out_steps = r_browse ? chr_pkg::STEPS_W'(r_step) : '1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_browse    <= 1'b0;
            r_step      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_browse    <= n_browse;
            r_step      <= n_step;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_read   <= n_is_read;
        r_zero      <= n_zero;
        r_offset    <= n_offset;
        r_out_read  <= n_out_read;
        r_out_len   <= n_out_len;
        r_out_data  <= n_out_data;
        r_out_steps <= n_out_steps;
    end

    chr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (chr_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (in_byte),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_q)
    );

    chr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (chr_pkg::SLOTS)
    ) u_lengths (
        .i_clk   (i_clk),
        .i_we    (ln_we),
        .i_waddr (ln_waddr),
        .i_wdata (ln_wdata),
        .i_re    (ln_re),
        .i_raddr (ln_raddr),
        .o_rdata (ln_q)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_read;
    assign o_m_axis_tdata  = {2'b00, r_out_steps, r_out_data, r_out_len};

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(chr_pkg::SLOTS))
        else $error("entry count above slot count");

    a_browse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_browse |-> (CNT_W'(r_step) < r_count))
        else $error("browse position past oldest entry");

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= BYTE_W'(chr_pkg::MAX_LEN))
        else $error("fill offset past maximum line length");

    a_push_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && req == chr_pkg::REQ_PUSH) |=> (r_state == S_IDLE))
        else $error("push word left the block busy");

    a_recall_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_read) |-> (r_out_data == '0))
        else $error("recall report with nonzero data byte");
`endif

endmodule
